// ===== rtl/core/cbse_pkg.sv =====
// Shared types, codes and helpers for the cubic B-spline point evaluator.
// No dependencies; cbse_front, cbse_back, the top level and the testbench refer to this package.
package cbse_pkg;

	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_EVAL   = 2'd2;

	localparam logic [1:0] STAT_DONE    = 2'd0;
	localparam logic [1:0] STAT_TOO_FEW = 2'd1;
	localparam logic [1:0] STAT_FULL    = 2'd2;

	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_CLAMP  = 2'd1;
	localparam logic [1:0] MODE_LOOP   = 2'd2;

	localparam logic [1:0] KIND_RESULT = 2'd0;
	localparam logic [1:0] KIND_APPEND = 2'd1;
	localparam logic [1:0] KIND_EVAL   = 2'd2;

	localparam logic REG_CURVE_MODE = 1'b0;
	localparam logic REG_LOOP_START = 1'b1;

	typedef struct packed {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [23:0] z;
		logic [15:0]        speed;
		logic signed [15:0] roll;
	} pt_t;

	localparam int PT_W = $bits(pt_t);

	typedef struct packed {
		logic [1:0]         action;
		logic signed [23:0] t;
		pt_t                pt;
	} in_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [1:0]         status;
		logic signed [23:0] u;
		pt_t                pt;
	} cmd_t;

	localparam int CMD_W = $bits(cmd_t);

	typedef struct packed {
		logic [1:0]         status;
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [23:0] z;
		logic signed [15:0] speed;
		logic signed [15:0] roll;
	} res_t;

	function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
		if (v > 64'sd8388607) begin
			return 24'sh7fffff;
		end else if (v < -64'sd8388608) begin
			return 24'sh800000;
		end
		return v[23:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
		if (v > 64'sd32767) begin
			return 16'sh7fff;
		end else if (v < -64'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

endpackage

// ===== rtl/core/cbse_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cbse_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);
	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== rtl/core/cbse_front.sv =====
// Front end: accepts input transactions, tracks the point count and turns each
// item into a command with segment indices and local parameter. Uses cbse_pkg.
module cbse_front #(
	parameter int MAX_POINTS = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  cbse_pkg::in_t                        item,
	input  logic [1:0]                           curve_mode,
	input  logic [5:0]                           loop_start,
	output logic                                 q_push,
	output cbse_pkg::cmd_t                       q_cmd,
	output logic [4*$clog2(MAX_POINTS)-1:0]      q_idx,
	input  logic                                 q_full
);
	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int XW = ((CW > 8) ? CW : 8) + 2;

	logic            s1_v_q;
	cbse_pkg::in_t   item_s1;
	logic [CW-1:0]   count_q;
	logic [2:0]      mod_k_q;
	logic [CW-1:0]   rem_q;

	logic [1:0]      mode_eff;
	logic            loop_mod;
	logic            done;
	logic            fire;
	logic [6:0]      seg7;
	logic [CW:0]     rem_sh;
	logic [CW-1:0]   rem_n;
	logic [XW-1:0]   nx;
	logic [XW-1:0]   segt;
	logic [XW-1:0]   segn;
	logic [XW-1:0]   lsx;
	logic [XW-1:0]   jv;
	logic [XW-1:0]   idx [4];

	assign seg7 = item_s1.t[22:16];

	always_comb begin
		case (curve_mode)
			cbse_pkg::MODE_CLAMP: mode_eff = cbse_pkg::MODE_CLAMP;
			cbse_pkg::MODE_LOOP:  mode_eff = item_s1.t[23] ? cbse_pkg::MODE_CLAMP
			                                               : cbse_pkg::MODE_LOOP;
			default:              mode_eff = cbse_pkg::MODE_NORMAL;
		endcase
	end

	assign loop_mod = (item_s1.action == cbse_pkg::ACT_EVAL) &&
	                  (mode_eff == cbse_pkg::MODE_LOOP) && (count_q != '0);
	assign done = !loop_mod || (mod_k_q == 3'd7);
	assign fire = s1_v_q && done && !q_full;
	assign full = s1_v_q && !(done && !q_full);
	assign q_push = fire;

	always_comb begin
		rem_sh = {rem_q, seg7[3'd6 - mod_k_q]};
		if (rem_sh >= {1'b0, count_q}) begin
			rem_n = CW'(rem_sh - {1'b0, count_q});
		end else begin
			rem_n = rem_sh[CW-1:0];
		end
	end

	always_comb begin
		nx = XW'(count_q);
		segt = item_s1.t[23] ? '0 : XW'(seg7);
		segn = (segt > nx - XW'(4)) ? nx - XW'(4) : segt;
		lsx = (XW'(loop_start) < nx) ? XW'(loop_start) : '0;
		jv = '0;
		for (int i = 0; i < 4; i++) begin
			idx[i] = '0;
		end
		q_cmd.kind = cbse_pkg::KIND_RESULT;
		q_cmd.status = cbse_pkg::STAT_DONE;
		q_cmd.u = '0;
		q_cmd.pt = item_s1.pt;
		unique case (item_s1.action)
			cbse_pkg::ACT_CLEAR: begin
				q_cmd.kind = cbse_pkg::KIND_RESULT;
			end
			cbse_pkg::ACT_APPEND: begin
				if (count_q == CW'(MAX_POINTS)) begin
					q_cmd.status = cbse_pkg::STAT_FULL;
				end else begin
					q_cmd.kind = cbse_pkg::KIND_APPEND;
					idx[0] = nx;
				end
			end
			cbse_pkg::ACT_EVAL: begin
				if (((mode_eff == cbse_pkg::MODE_NORMAL) && (count_q < CW'(4))) ||
				    (count_q == '0)) begin
					q_cmd.status = cbse_pkg::STAT_TOO_FEW;
				end else begin
					q_cmd.kind = cbse_pkg::KIND_EVAL;
					case (mode_eff)
						cbse_pkg::MODE_NORMAL: begin
							q_cmd.u = {item_s1.t[23:16] - segn[7:0], item_s1.t[15:0]};
							for (int i = 0; i < 4; i++) begin
								idx[i] = segn + XW'(i);
							end
						end
						cbse_pkg::MODE_CLAMP: begin
							q_cmd.u = {8'd0, item_s1.t[15:0]};
							for (int i = 0; i < 4; i++) begin
								jv = {{(XW-8){item_s1.t[23]}}, item_s1.t[23:16]} + XW'(i);
								if (jv[XW-1]) begin
									idx[i] = '0;
								end else if (jv > nx - XW'(1)) begin
									idx[i] = nx - XW'(1);
								end else begin
									idx[i] = jv;
								end
							end
						end
						default: begin
							q_cmd.u = {8'd0, item_s1.t[15:0]};
							idx[0] = XW'(rem_q);
							for (int i = 1; i < 4; i++) begin
								idx[i] = (idx[i-1] + XW'(1) == nx) ? lsx : idx[i-1] + XW'(1);
							end
						end
					endcase
				end
			end
			default: begin
				q_cmd.kind = cbse_pkg::KIND_RESULT;
			end
		endcase
		for (int i = 0; i < 4; i++) begin
			q_idx[i*IW +: IW] = idx[i][IW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			count_q <= '0;
			mod_k_q <= '0;
		end else begin
			if (push && !full) begin
				s1_v_q <= 1'b1;
				mod_k_q <= '0;
			end else begin
				if (fire) begin
					s1_v_q <= 1'b0;
				end
				if (s1_v_q && loop_mod && (mod_k_q != 3'd7)) begin
					mod_k_q <= mod_k_q + 3'd1;
				end
			end
			if (fire) begin
				if (item_s1.action == cbse_pkg::ACT_CLEAR) begin
					count_q <= '0;
				end else if ((item_s1.action == cbse_pkg::ACT_APPEND) &&
				             (count_q != CW'(MAX_POINTS))) begin
					count_q <= count_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			item_s1 <= item;
			rem_q <= '0;
		end else if (s1_v_q && loop_mod && (mod_k_q != 3'd7)) begin
			rem_q <= rem_n;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_POINTS))
		else $error("point count beyond table size");
	a_push_only_held: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> s1_v_q)
		else $error("command issued without a held item");
endmodule

// ===== rtl/core/cbse_cmdq.sv =====
// Two-entry command queue between the front end and the back end.
// No package dependency; the entry is a flat vector.
module cbse_cmdq #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         empty
);
	logic [W-1:0] mem_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("command queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("command queue underflow");
endmodule

// ===== rtl/core/cbse_back.sv =====
// Back end: executes appends into the point table and evaluates the curve with
// one shared multiplier, a byte-serial divide-by-six and five accumulators.
// Uses cbse_pkg and cbse_ram.
module cbse_back #(
	parameter int MAX_POINTS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cq_valid,
	input  cbse_pkg::cmd_t                  cq_cmd,
	input  logic [4*$clog2(MAX_POINTS)-1:0] cq_idx,
	output logic                            cq_pop,
	output logic                            res_valid,
	output cbse_pkg::res_t                  res,
	input  logic                            res_pop
);
	localparam int IW = $clog2(MAX_POINTS);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL   = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_BLEND = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	logic [2:0]          state_q;
	logic [3:0]          step_q;
	logic [1:0]          wi_q;
	logic signed [23:0]  u_q;
	logic [IW-1:0]       idx_q [4];
	logic signed [31:0]  u2_q;
	logic signed [31:0]  w2_q;
	logic signed [39:0]  u3_q;
	logic signed [39:0]  w3_q;
	logic signed [39:0]  b_q [4];
	logic signed [57:0]  prod_s1;
	logic                acc_en_s1;
	logic [2:0]          acc_ch_s1;
	logic                acc_hi_s1;
	logic signed [63:0]  acc_q [5];
	logic [47:0]         m_q;
	logic [47:0]         q_q;
	logic [2:0]          r_q;
	logic                neg_q;
	logic                res_v_q;
	cbse_pkg::res_t      res_q;

	logic signed [24:0]  w;
	logic signed [32:0]  mul_a;
	logic signed [24:0]  mul_b;
	logic [3:0]          sel;
	logic [2:0]          ch;
	logic signed [57:0]  rnd_p;
	logic signed [41:0]  u3e;
	logic signed [41:0]  u2e;
	logic signed [41:0]  ue;
	logic signed [41:0]  num;
	logic [41:0]         mag;
	logic [10:0]         dx;
	logic [20:0]         dprod;
	logic [7:0]          qd;
	logic [10:0]         drem;
	logic [47:0]         q_n;
	logic signed [39:0]  bval;
	logic signed [63:0]  prod64;
	logic signed [63:0]  addend;
	logic signed [63:0]  r16 [5];
	logic signed [63:0]  r17;
	logic                slot_ok;
	logic                idle_res;
	logic                fin_res;
	logic                res_wr;
	cbse_pkg::res_t      res_next;
	cbse_pkg::pt_t       rd_pt;
	logic [cbse_pkg::PT_W-1:0] rd_data;

	assign w = 25'sd65536 - {u_q[23], u_q};
	assign sel = step_q - 4'd1;
	assign ch = sel[3:1];
	assign rd_pt = rd_data;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == S_MUL) begin
			case (step_q)
				4'd0: begin
					mul_a = {{9{u_q[23]}}, u_q};
					mul_b = {u_q[23], u_q};
				end
				4'd1: begin
					mul_a = {{8{w[24]}}, w};
					mul_b = w;
				end
				4'd2: begin
					mul_a = {u2_q[31], u2_q};
					mul_b = {u_q[23], u_q};
				end
				default: begin
					mul_a = {w2_q[31], w2_q};
					mul_b = w;
				end
			endcase
		end else begin
			mul_a = sel[0] ? {{13{b_q[wi_q][39]}}, b_q[wi_q][39:20]}
			               : {13'd0, b_q[wi_q][19:0]};
			case (ch)
				3'd0:    mul_b = {rd_pt.x[23], rd_pt.x};
				3'd1:    mul_b = {rd_pt.y[23], rd_pt.y};
				3'd2:    mul_b = {rd_pt.z[23], rd_pt.z};
				3'd3:    mul_b = {9'd0, rd_pt.speed};
				default: mul_b = {{9{rd_pt.roll[15]}}, rd_pt.roll};
			endcase
		end
	end

	assign rnd_p = (prod_s1 + 58'sd32768) >>> 16;

	always_comb begin
		u3e = {{2{u3_q[39]}}, u3_q};
		u2e = {{10{u2_q[31]}}, u2_q};
		ue = {{18{u_q[23]}}, u_q};
		case (wi_q)
			2'd0:    num = {{2{w3_q[39]}}, w3_q};
			2'd1:    num = (u3e <<< 1) + u3e - (u2e <<< 2) - (u2e <<< 1) + 42'sd262144;
			2'd2:    num = (u2e <<< 1) + u2e - (u3e <<< 1) - u3e + (ue <<< 1) + ue
			               + 42'sd65536;
			default: num = u3e;
		endcase
		mag = num[41] ? 42'(-num) : num;
	end

	always_comb begin
		dx = {r_q, m_q[47:40]};
		dprod = 21'(dx) * 21'd683;
		qd = dprod[19:12];
		drem = dx - 11'(qd) * 11'd6;
		q_n = {q_q[39:0], qd};
		bval = neg_q ? 40'(-$signed(q_n[39:0])) : $signed(q_n[39:0]);
	end

	assign prod64 = {{6{prod_s1[57]}}, prod_s1};
	assign addend = acc_hi_s1 ? (prod64 <<< 20) : prod64;

	always_comb begin
		for (int c = 0; c < 5; c++) begin
			r16[c] = (acc_q[c] + 64'sd32768) >>> 16;
		end
		r17 = (acc_q[3] + 64'sd65536) >>> 17;
	end

	assign slot_ok = !res_v_q || res_pop;
	assign idle_res = (state_q == S_IDLE) && cq_valid &&
	                  (cq_cmd.kind != cbse_pkg::KIND_EVAL) && slot_ok;
	assign fin_res = (state_q == S_FIN) && (step_q == 4'd1) && slot_ok;
	assign res_wr = idle_res || fin_res;
	assign cq_pop = (state_q == S_IDLE) && cq_valid &&
	                ((cq_cmd.kind == cbse_pkg::KIND_EVAL) || slot_ok);

	always_comb begin
		res_next = '0;
		if (fin_res) begin
			res_next.status = cbse_pkg::STAT_DONE;
			res_next.x = cbse_pkg::sat24(r16[0]);
			res_next.y = cbse_pkg::sat24(r16[1]);
			res_next.z = cbse_pkg::sat24(r16[2]);
			res_next.speed = cbse_pkg::sat16(r17);
			res_next.roll = cbse_pkg::sat16(r16[4]);
		end else begin
			res_next.status = cq_cmd.status;
		end
	end

	cbse_ram #(
		.W(cbse_pkg::PT_W),
		.DEPTH(MAX_POINTS)
	) u_table (
		.clk(clk),
		.we(idle_res && (cq_cmd.kind == cbse_pkg::KIND_APPEND)),
		.waddr(cq_idx[IW-1:0]),
		.wdata(cq_cmd.pt),
		.re((state_q == S_BLEND) && (step_q == 4'd0)),
		.raddr(idx_q[wi_q]),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= '0;
			wi_q <= '0;
			res_v_q <= 1'b0;
			acc_en_s1 <= 1'b0;
		end else begin
			acc_en_s1 <= (state_q == S_BLEND) && (step_q != 4'd0);
			if (res_wr) begin
				res_v_q <= 1'b1;
			end else if (res_pop) begin
				res_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cq_valid && (cq_cmd.kind == cbse_pkg::KIND_EVAL)) begin
						state_q <= S_MUL;
						step_q <= '0;
					end
				end
				S_MUL: begin
					if (step_q == 4'd4) begin
						state_q <= S_DIV;
						step_q <= '0;
						wi_q <= '0;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				S_DIV: begin
					if (step_q == 4'd6) begin
						step_q <= '0;
						wi_q <= wi_q + 2'd1;
						if (wi_q == 2'd3) begin
							state_q <= S_BLEND;
						end
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				S_BLEND: begin
					if (step_q == 4'd10) begin
						step_q <= '0;
						wi_q <= wi_q + 2'd1;
						if (wi_q == 2'd3) begin
							state_q <= S_FIN;
						end
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				S_FIN: begin
					if (step_q == 4'd0) begin
						step_q <= 4'd1;
					end else if (slot_ok) begin
						state_q <= S_IDLE;
						step_q <= '0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		acc_ch_s1 <= ch;
		acc_hi_s1 <= sel[0];
		if (res_wr) begin
			res_q <= res_next;
		end
		if ((state_q == S_IDLE) && cq_valid && (cq_cmd.kind == cbse_pkg::KIND_EVAL)) begin
			u_q <= cq_cmd.u;
			for (int i = 0; i < 4; i++) begin
				idx_q[i] <= cq_idx[i*IW +: IW];
			end
		end
		if (state_q == S_MUL) begin
			case (step_q)
				4'd1:    u2_q <= rnd_p[31:0];
				4'd2:    w2_q <= rnd_p[31:0];
				4'd3:    u3_q <= rnd_p[39:0];
				4'd4:    w3_q <= rnd_p[39:0];
				default: u2_q <= u2_q;
			endcase
		end
		if (state_q == S_DIV) begin
			if (step_q == 4'd0) begin
				neg_q <= num[41];
				m_q <= 48'(mag) + 48'd3;
				r_q <= '0;
				q_q <= '0;
			end else begin
				m_q <= {m_q[39:0], 8'd0};
				r_q <= drem[2:0];
				q_q <= q_n;
				if (step_q == 4'd6) begin
					b_q[wi_q] <= bval;
				end
			end
			if ((step_q == 4'd6) && (wi_q == 2'd3)) begin
				for (int c = 0; c < 5; c++) begin
					acc_q[c] <= '0;
				end
			end
		end
		if (acc_en_s1) begin
			for (int c = 0; c < 5; c++) begin
				if (acc_ch_s1 == 3'(c)) begin
					acc_q[c] <= acc_q[c] + addend;
				end
			end
		end
	end

	assign res_valid = res_v_q;
	assign res = res_q;

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !cq_pop)
		else $error("command taken while an evaluation is in progress");
	a_acc_only_blend: assert property (@(posedge clk) disable iff (!arst_n)
		acc_en_s1 |-> ((state_q == S_BLEND) || (state_q == S_FIN)))
		else $error("accumulate outside the blend phase");
endmodule

// ===== rtl/core/cubic_bspline_point_evaluator.sv =====
// Top level of the cubic B-spline point evaluator: configuration registers,
// front end, command queue and back end. Uses cbse_pkg, cbse_front,
// cbse_cmdq and cbse_back.
//
// Channel   Handshake            Carries
// input     push / full          action, param_t, point_*_in
// result    empty / pop          status, out_x, out_y, out_z, out_speed, out_roll
// config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Clear, append and rejected items are completed by the back end from its idle state.
// An evaluation runs in the back end on the shared multiplier for the powers of u, then
// on the byte-serial divide-by-six for the four weights, then blends four points over
// five channels with two partial products each, and then finishes. Loop mode adds a
// bit-serial segment modulo in the front end. A two-entry command queue lets the front
// end keep accepting while the back end works or waits on a full result register.
// Reset clears the point count and both configuration registers.
module cubic_bspline_point_evaluator #(
	parameter int MAX_POINTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         action,
	input  logic signed [23:0] param_t,
	input  logic signed [23:0] point_x_in,
	input  logic signed [23:0] point_y_in,
	input  logic signed [23:0] point_z_in,
	input  logic [15:0]        point_speed_in,
	input  logic signed [15:0] point_roll_in,
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         status,
	output logic signed [23:0] out_x,
	output logic signed [23:0] out_y,
	output logic signed [23:0] out_z,
	output logic signed [15:0] out_speed,
	output logic signed [15:0] out_roll,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [5:0]         cfg_data
);
	localparam int IW = $clog2(MAX_POINTS);

	logic [1:0]     curve_mode_q;
	logic [5:0]     loop_start_q;
	cbse_pkg::in_t  item;
	logic           q_push;
	cbse_pkg::cmd_t q_cmd;
	logic [4*IW-1:0] q_idx;
	logic           q_full;
	logic           q_empty;
	logic           q_pop;
	logic [cbse_pkg::CMD_W+4*IW-1:0] q_rdata;
	cbse_pkg::cmd_t h_cmd;
	logic [4*IW-1:0] h_idx;
	logic           res_valid;
	cbse_pkg::res_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_mode_q <= cbse_pkg::MODE_NORMAL;
			loop_start_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cbse_pkg::REG_CURVE_MODE: curve_mode_q <= cfg_data[1:0];
				cbse_pkg::REG_LOOP_START: loop_start_q <= cfg_data;
				default: curve_mode_q <= curve_mode_q;
			endcase
		end
	end

	assign item.action = action;
	assign item.t = param_t;
	assign item.pt.x = point_x_in;
	assign item.pt.y = point_y_in;
	assign item.pt.z = point_z_in;
	assign item.pt.speed = point_speed_in;
	assign item.pt.roll = point_roll_in;

	cbse_front #(
		.MAX_POINTS(MAX_POINTS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.curve_mode(curve_mode_q),
		.loop_start(loop_start_q),
		.q_push(q_push),
		.q_cmd(q_cmd),
		.q_idx(q_idx),
		.q_full(q_full)
	);

	cbse_cmdq #(
		.W(cbse_pkg::CMD_W + 4*IW)
	) u_cmdq (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wdata({q_cmd, q_idx}),
		.pop(q_pop),
		.rdata(q_rdata),
		.full(q_full),
		.empty(q_empty)
	);

	assign h_cmd = q_rdata[cbse_pkg::CMD_W+4*IW-1:4*IW];
	assign h_idx = q_rdata[4*IW-1:0];

	cbse_back #(
		.MAX_POINTS(MAX_POINTS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cq_valid(!q_empty),
		.cq_cmd(h_cmd),
		.cq_idx(h_idx),
		.cq_pop(q_pop),
		.res_valid(res_valid),
		.res(res),
		.res_pop(pop && res_valid)
	);

	assign empty = !res_valid;
	assign status = res.status;
	assign out_x = res.x;
	assign out_y = res.y;
	assign out_z = res.z;
	assign out_speed = res.speed;
	assign out_roll = res.roll;
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for cubic_bspline_point_evaluator, built on cbse_pkg.
// A built-in predictor of the table and the B-spline arithmetic checks every result transaction.
module testbench;
	localparam longint SAT = 64'sd1 << 61;
	localparam int NPTS = 64;

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic full;
	logic [1:0] action = cbse_pkg::ACT_CLEAR;
	logic signed [23:0] param_t = 0;
	logic signed [23:0] point_x_in = 0, point_y_in = 0, point_z_in = 0;
	logic [15:0] point_speed_in = 0;
	logic signed [15:0] point_roll_in = 0;
	logic empty;
	logic pop = 0;
	logic [1:0] status;
	logic signed [23:0] out_x, out_y, out_z;
	logic signed [15:0] out_speed, out_roll;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic cfg_index = cbse_pkg::REG_CURVE_MODE;
	logic [5:0] cfg_data = 0;

	longint tab_x[NPTS], tab_y[NPTS], tab_z[NPTS], tab_speed[NPTS], tab_roll[NPTS];
	int n_points = 0;
	logic [1:0] mode_reg = cbse_pkg::MODE_NORMAL;
	logic [5:0] wrap_reg = 0;
	cbse_pkg::res_t expected_results[$];
	int errors = 0;
	bit calm = 0;

	cubic_bspline_point_evaluator u_dut (.*);

	always #2 clk = ~clk;

	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic longint lim(longint v);
		if (v > SAT) return SAT;
		if (v < -SAT) return -SAT;
		return v;
	endfunction

	function automatic longint sadd(longint a, longint b);
		return lim(lim(a) + lim(b));
	endfunction

	function automatic longint smul(longint a, longint b);
		longint unsigned ua, ub;
		longint r;
		a = lim(a);
		b = lim(b);
		ua = a < 0 ? -a : a;
		ub = b < 0 ? -b : b;
		if (ua != 0 && ub > longint'(SAT) / ua) r = SAT;
		else r = lim(longint'(ua * ub));
		return ((a < 0) != (b < 0)) ? -r : r;
	endfunction

	function automatic longint rnd(longint x, int s);
		return sadd(x, 64'sd1 << (s - 1)) >>> s;
	endfunction

	function automatic longint div6(longint x);
		x = lim(x);
		if (x >= 0) return (x + 3) / 6;
		return -((-x + 3) / 6);
	endfunction

	function automatic longint clip(longint v, int w);
		longint hi;
		hi = (64'sd1 <<< (w - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	function automatic longint blend_channel(ref longint tab[NPTS], input int idx[4],
		input longint b[4], input int s, input int w);
		longint acc;
		acc = 0;
		for (int i = 0; i < 4; i++) acc = sadd(acc, smul(b[i], tab[idx[i]]));
		return clip(rnd(acc, s), w);
	endfunction

	function automatic cbse_pkg::res_t predict_result(logic [1:0] act,
		logic signed [23:0] t_in,
		logic signed [23:0] px, logic signed [23:0] py, logic signed [23:0] pz,
		logic [15:0] ps, logic signed [15:0] pr);
		cbse_pkg::res_t r;
		longint t, seg, u, u2, u3, w, w3, j;
		longint b[4];
		int idx[4];
		int ls;
		logic [1:0] md;
		r = '0;
		t = longint'(t_in);
		md = (mode_reg == 2'd3) ? cbse_pkg::MODE_NORMAL : mode_reg;
		if (act == cbse_pkg::ACT_CLEAR) begin
			n_points = 0;
			return r;
		end
		if (act == cbse_pkg::ACT_APPEND) begin
			if (n_points >= NPTS) begin
				r.status = cbse_pkg::STAT_FULL;
				return r;
			end
			tab_x[n_points] = longint'(px);
			tab_y[n_points] = longint'(py);
			tab_z[n_points] = longint'(pz);
			tab_speed[n_points] = longint'(ps);
			tab_roll[n_points] = longint'(pr);
			n_points++;
			return r;
		end
		if (act != cbse_pkg::ACT_EVAL) return r;
		if (md == cbse_pkg::MODE_LOOP && t < 0) md = cbse_pkg::MODE_CLAMP;
		if ((md == cbse_pkg::MODE_NORMAL && n_points < 4) || n_points == 0) begin
			r.status = cbse_pkg::STAT_TOO_FEW;
			return r;
		end
		if (md == cbse_pkg::MODE_NORMAL) begin
			seg = t < 0 ? 0 : (t >>> 16);
			if (seg > n_points - 4) seg = n_points - 4;
			u = t - seg * 65536;
			for (int i = 0; i < 4; i++) idx[i] = int'(seg + i);
		end else if (md == cbse_pkg::MODE_CLAMP) begin
			seg = t >>> 16;
			u = t - seg * 65536;
			for (int i = 0; i < 4; i++) begin
				j = seg + i;
				if (j < 0) j = 0;
				if (j > n_points - 1) j = n_points - 1;
				idx[i] = int'(j);
			end
		end else begin
			ls = (int'(wrap_reg) < n_points) ? int'(wrap_reg) : 0;
			j = (t >>> 16) % n_points;
			u = t & 64'hFFFF;
			idx[0] = int'(j);
			for (int i = 1; i < 4; i++) begin
				j++;
				if (j >= n_points) j -= n_points - ls;
				idx[i] = int'(j);
			end
		end
		u2 = rnd(smul(u, u), 16);
		u3 = rnd(smul(u2, u), 16);
		w = sadd(65536, -u);
		w3 = rnd(smul(rnd(smul(w, w), 16), w), 16);
		b[0] = div6(w3);
		b[1] = div6(sadd(sadd(smul(3, u3), smul(-6, u2)), 262144));
		b[2] = div6(sadd(sadd(smul(-3, u3), smul(3, u2)), sadd(smul(3, u), 65536)));
		b[3] = div6(u3);
		r.x = 24'(blend_channel(tab_x, idx, b, 16, 24));
		r.y = 24'(blend_channel(tab_y, idx, b, 16, 24));
		r.z = 24'(blend_channel(tab_z, idx, b, 16, 24));
		r.speed = 16'(blend_channel(tab_speed, idx, b, 17, 16));
		r.roll = 16'(blend_channel(tab_roll, idx, b, 16, 16));
		return r;
	endfunction

	task automatic send_item(logic [1:0] act, logic signed [23:0] t,
		logic signed [23:0] px = 0, logic signed [23:0] py = 0, logic signed [23:0] pz = 0,
		logic [15:0] ps = 0, logic signed [15:0] pr = 0);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			push <= 0;
			repeat (gap) @(posedge clk);
		end
		push <= 1;
		action <= act;
		param_t <= t;
		point_x_in <= px;
		point_y_in <= py;
		point_z_in <= pz;
		point_speed_in <= ps;
		point_roll_in <= pr;
		do @(posedge clk); while (full);
		expected_results.push_back(predict_result(act, t, px, py, pz, ps, pr));
	endtask

	task automatic append_random();
		send_item(cbse_pkg::ACT_APPEND, 24'($urandom), 24'($urandom), 24'($urandom),
			24'($urandom), 16'($urandom), 16'($urandom));
	endtask

	task automatic drain();
		push <= 0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [5:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == cbse_pkg::REG_CURVE_MODE) mode_reg = val[1:0];
		else wrap_reg = val;
	endtask

	task automatic set_mode(logic [1:0] md, logic [5:0] ls);
		drain();
		write_reg(cbse_pkg::REG_CURVE_MODE, {4'd0, md});
		write_reg(cbse_pkg::REG_LOOP_START, ls);
		cfg_valid <= 0;
	endtask

	initial begin
		cbse_pkg::res_t e;
		int wait_cycles;
		forever begin
			wait_cycles = calm ? 0 : $urandom_range(0, 15);
			if (wait_cycles > 0) begin
				pop <= 0;
				repeat (wait_cycles) @(posedge clk);
			end
			pop <= 1;
			do @(posedge clk); while (empty);
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= 10) $display("Unexpected result transaction, status %0d", status);
			end else begin
				e = expected_results.pop_front();
				if (status !== e.status || out_x !== e.x || out_y !== e.y || out_z !== e.z ||
					out_speed !== e.speed || out_roll !== e.roll) begin
					errors++;
					if (errors <= 10) begin
						$display("Mismatch: expected st=%0d x=%0d y=%0d z=%0d sp=%0d rl=%0d",
							e.status, e.x, e.y, e.z, e.speed, e.roll);
						$display("          actual   st=%0d x=%0d y=%0d z=%0d sp=%0d rl=%0d",
							status, out_x, out_y, out_z, out_speed, out_roll);
					end
				end
			end
		end
	end

	task automatic test_basic();
		send_item(cbse_pkg::ACT_CLEAR, 0);
		send_item(cbse_pkg::ACT_EVAL, 0);
		send_item(2'd3, 24'sh7fffff);
		send_item(cbse_pkg::ACT_APPEND, 0, 24'sh7fffff, 24'sh800000, 24'sh7fffff, 16'hffff,
			16'sh7fff);
		send_item(cbse_pkg::ACT_APPEND, 0, 24'sh800000, 24'sh7fffff, 24'sh800000, 16'h0000,
			16'sh8000);
		send_item(cbse_pkg::ACT_APPEND, 0, 24'sh7fffff, 24'sh7fffff, 24'sh800000, 16'hffff,
			16'sh7fff);
		send_item(cbse_pkg::ACT_EVAL, 24'sh008000);
		send_item(cbse_pkg::ACT_APPEND, 0, 24'sh800000, 24'sh800000, 24'sh7fffff, 16'h8000,
			16'sh8000);
		send_item(cbse_pkg::ACT_EVAL, 0);
		send_item(cbse_pkg::ACT_EVAL, 24'sh018000);
		send_item(cbse_pkg::ACT_EVAL, 24'sh7fffff);
		send_item(cbse_pkg::ACT_EVAL, 24'sh800000);
		send_item(cbse_pkg::ACT_EVAL, 24'sh00ffff);
	endtask

	task automatic test_modes();
		logic signed [23:0] probes[6] = '{24'sh800000, -24'sh018000, 24'sh000000,
			24'sh02c000, 24'sh05ffff, 24'sh7fffff};
		logic [1:0] modes[5] = '{cbse_pkg::MODE_CLAMP, cbse_pkg::MODE_LOOP,
			cbse_pkg::MODE_LOOP, cbse_pkg::MODE_LOOP, 2'd3};
		logic [5:0] starts[5] = '{6'd0, 6'd2, 6'd63, 6'd0, 6'd5};
		for (int m = 0; m < 5; m++) begin
			set_mode(modes[m], starts[m]);
			foreach (probes[i]) send_item(cbse_pkg::ACT_EVAL, probes[i]);
		end
		send_item(cbse_pkg::ACT_CLEAR, 0);
		append_random();
		send_item(cbse_pkg::ACT_EVAL, 24'sh012345);
		send_item(cbse_pkg::ACT_EVAL, -24'sh012345);
	endtask

	task automatic test_full_table();
		send_item(cbse_pkg::ACT_CLEAR, 0);
		repeat (NPTS) append_random();
		append_random();
		set_mode(cbse_pkg::MODE_LOOP, 6'd60);
		send_item(cbse_pkg::ACT_EVAL, 24'sh3f8000);
		send_item(cbse_pkg::ACT_EVAL, 24'sh7fffff);
		set_mode(cbse_pkg::MODE_NORMAL, 6'd0);
		send_item(cbse_pkg::ACT_EVAL, 24'sh3e0000);
	endtask

	task automatic test_random();
		int sent, k, sel, evals;
		logic signed [23:0] t;
		sent = 0;
		while (sent < 1150) begin
			calm = ($urandom_range(0, 3) == 0);
			set_mode(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)));
			send_item(cbse_pkg::ACT_CLEAR, 0);
			k = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 66) : $urandom_range(1, 12);
			repeat (k) append_random();
			sent += k + 1;
			evals = $urandom_range(4, 14);
			for (int i = 0; i < evals; i++) begin
				sel = $urandom_range(0, 9);
				if (sel < 6) t = 24'($urandom_range(0, (k + 2) * 65536) - 65536);
				else if (sel < 8) t = 24'($urandom);
				else t = 24'(($urandom_range(0, 1) ? int'($urandom_range(0, 7))
					: -int'($urandom_range(1, 7))) * 65536 + int'($urandom_range(0, 65535)));
				if ($urandom_range(0, 15) == 0) send_item(2'($urandom), 24'($urandom),
					24'($urandom), 24'($urandom), 24'($urandom), 16'($urandom),
					16'($urandom));
				else send_item(cbse_pkg::ACT_EVAL, t);
				sent++;
			end
		end
		calm = 0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_basic();
		test_modes();
		test_full_table();
		test_random();
		drain();
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule
